[rtl/lrsp_pkg.sv]
// ----------------------------------------------------------------------------
// Life rule string parser package
// Shared types, phase codes and character constants for the rule parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lrsp_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned BirthWidth = 8;
    localparam int unsigned SurvWidth  = 9;
    localparam int unsigned CountWidth = 5;
    localparam int unsigned StateField = 4;
    localparam int unsigned WordWidth  = SurvWidth + BirthWidth + StateField;

    localparam logic [CharWidth-1:0]  CharZero  = 8'h30;
    localparam logic [CharWidth-1:0]  CharOne   = 8'h31;
    localparam logic [CharWidth-1:0]  CharEight = 8'h38;
    localparam logic [CharWidth-1:0]  CharNine  = 8'h39;
    localparam logic [CharWidth-1:0]  CharSlash = 8'h2F;
    localparam logic [CharWidth-1:0]  CharS     = 8'h53;
    localparam logic [CountWidth-1:0] CountMin  = 5'd2;
    localparam logic [CountWidth-1:0] CountMax  = 5'd17;
    localparam logic [CountWidth-1:0] CountSat  = 5'd31;

    // Depth of the result buffer that decouples the two channels.
    localparam int unsigned BufDepth = 2;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_BIRTH   = 3'd1,
        PH_SEP_S   = 3'd2,
        PH_SURVIVE = 3'd3,
        PH_COUNT   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [CharWidth-1:0] char_code;
        logic                 last_char;
    } char_item_t;

    typedef struct packed {
        logic                 rule_ok;
        logic [WordWidth-1:0] rule_word;
    } verdict_item_t;

    typedef struct packed {
        phase_t                phase;
        logic [BirthWidth-1:0] birth_mask;
        logic [SurvWidth-1:0]  survive_mask;
        logic [CountWidth-1:0] count_value;
        logic                  count_seen;
        logic                  bad_flag;
    } parse_state_t;

    localparam parse_state_t StateReset = '{
        phase:        PH_FIRST,
        birth_mask:   '0,
        survive_mask: '0,
        count_value:  '0,
        count_seen:   1'b0,
        bad_flag:     1'b0
    };

endpackage

`default_nettype wire

[rtl/life_rule_string_parser.sv]
// ----------------------------------------------------------------------------
// Life rule string parser
// Parses B.../S.../N rule strings one character per request into a rule word.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle while char_stall is low and
// gives one verdict when the character marked as last arrives. A character is
// captured in an input register; the step logic updates the parse state from
// it as it leaves that register, and on the last character the verdict enters
// the result buffer (two entries by default), from which the consumer takes
// it when verdict_stall is low. The sustained rate is one character per cycle
// while the input is not stalled, set by the single parse-state update that
// each character needs. The input side stalls only when a last character
// waits in the input register and the result buffer is full; plain characters
// never wait for the result side. The first character of each string is
// skipped (it is taken to be B). A valid verdict carries the survive mask in
// bits 0-8, the birth mask in bits 9-16 (digit d at bit d + 8) and the state
// count minus two in bits 17-20; an invalid one carries a zero word. After
// each verdict the parser is ready for a new string.
// ----------------------------------------------------------------------------
`default_nettype none

module life_rule_string_parser
    import lrsp_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = BufDepth
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                char_valid,
    output logic               char_stall,
    input  wire char_item_t    char_item,
    output logic               verdict_valid,
    input  wire                verdict_stall,
    output verdict_item_t      verdict_item
);

    // Input register: one captured request waiting for the step logic.
    logic          in_valid_reg;
    logic          in_valid_next;
    char_item_t    in_item_reg;

    // Parse state carried from character to character.
    parse_state_t  state_reg;
    parse_state_t  state_next;

    verdict_item_t step_verdict;
    logic          buf_full;
    logic          advance;
    logic          push;
    logic          accept;

    // A captured character moves on unless it closes a string and the
    // result buffer has no room for its verdict.
    assign advance    = in_valid_reg && !(in_item_reg.last_char && buf_full);
    assign push       = advance && in_item_reg.last_char;
    assign char_stall = in_valid_reg && !advance;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
    end

    lrsp_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .verdict    (step_verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= StateReset;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= char_item;
        end
    end

    lrsp_obuf #(
        .DEPTH (BUF_DEPTH)
    ) u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_item     (step_verdict),
        .full          (buf_full),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict_item  (verdict_item)
    );

    // A string always closes with the parser back at its start.
    assert property (@(posedge clk) disable iff (!rst_n)
                     push |=> state_reg == StateReset)
        else $error("parse state not cleared after verdict");
    // Invalid verdicts carry a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (verdict_valid && !verdict_item.rule_ok) |-> verdict_item.rule_word == '0)
        else $error("invalid verdict with nonzero rule word");
    // Stalls come only from a closing character facing a full buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
                     char_stall |-> (in_item_reg.last_char && buf_full))
        else $error("input stalled without cause");
    // The error flag is sticky until the string closes.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg.bad_flag && !(advance && in_item_reg.last_char))
                     |=> state_reg.bad_flag)
        else $error("error flag dropped inside a string");

endmodule

`default_nettype wire

[rtl/lrsp_step.sv]
// ----------------------------------------------------------------------------
// Rule parser step
// Next-state and verdict logic for one character of the rule string.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsp_step
    import lrsp_pkg::*;
(
    input  wire parse_state_t  state,
    input  wire char_item_t    item,
    output parse_state_t       state_next,
    output verdict_item_t      verdict
);

    parse_state_t            consumed;
    logic [CharWidth-1:0]    c;
    logic [CharWidth-1:0]    off_one;
    logic [CharWidth-1:0]    off_zero;
    logic [9:0]              count_sum;
    logic                    ok;
    logic [CountWidth-1:0]   states_m2;

    assign c        = item.char_code;
    assign off_one  = c - CharOne;
    assign off_zero = c - CharZero;
    // Worst case is 31 * 10 + 9, which fits in ten bits.
    assign count_sum = ({5'd0, state.count_value} * 10'd10) + {6'd0, off_zero[3:0]};

    always_comb
    begin
        consumed = state;
        if (!state.bad_flag)
        begin
            case (state.phase)
                PH_FIRST:
                begin
                    consumed.phase = PH_BIRTH;
                end
                PH_BIRTH:
                begin
                    if (c >= CharOne && c <= CharEight)
                    begin
                        consumed.birth_mask[off_one[2:0]] = 1'b1;
                    end
                    else if (c == CharSlash && state.birth_mask != '0)
                    begin
                        consumed.phase = PH_SEP_S;
                    end
                    else
                    begin
                        consumed.bad_flag = 1'b1;
                    end
                end
                PH_SEP_S:
                begin
                    if (c == CharS)
                    begin
                        consumed.phase = PH_SURVIVE;
                    end
                    else
                    begin
                        consumed.bad_flag = 1'b1;
                    end
                end
                PH_SURVIVE:
                begin
                    if (c >= CharZero && c <= CharEight)
                    begin
                        consumed.survive_mask[off_zero[3:0]] = 1'b1;
                    end
                    else if (c == CharSlash)
                    begin
                        consumed.phase = PH_COUNT;
                    end
                    else
                    begin
                        consumed.bad_flag = 1'b1;
                    end
                end
                PH_COUNT:
                begin
                    if (c >= CharZero && c <= CharNine)
                    begin
                        consumed.count_value = (count_sum > {5'd0, CountSat}) ?
                                               CountSat : count_sum[CountWidth-1:0];
                        consumed.count_seen  = 1'b1;
                    end
                    else
                    begin
                        consumed.bad_flag = 1'b1;
                    end
                end
                default:
                begin
                    consumed.bad_flag = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        ok        = 1'b0;
        states_m2 = '0;
        if (!consumed.bad_flag && consumed.birth_mask != '0)
        begin
            if (consumed.phase == PH_SURVIVE)
            begin
                ok = 1'b1;
            end
            else if (consumed.phase == PH_COUNT && consumed.count_seen &&
                     consumed.count_value >= CountMin && consumed.count_value <= CountMax)
            begin
                ok        = 1'b1;
                states_m2 = consumed.count_value - CountMin;
            end
        end
    end

    assign verdict.rule_ok   = ok;
    assign verdict.rule_word = ok ? {states_m2[StateField-1:0], consumed.birth_mask,
                                     consumed.survive_mask} : '0;

    // The final character closes the string and the parser starts over.
    assign state_next = item.last_char ? StateReset : consumed;

endmodule

`default_nettype wire

[rtl/lrsp_obuf.sv]
// ----------------------------------------------------------------------------
// Rule parser result buffer
// Small register FIFO that holds verdicts until the consumer takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsp_obuf
    import lrsp_pkg::*;
#(
    parameter int unsigned DEPTH = BufDepth
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire verdict_item_t push_item,
    output logic               full,
    output logic               verdict_valid,
    input  wire                verdict_stall,
    output verdict_item_t      verdict_item
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);

    verdict_item_t         entry_reg [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg;
    logic [PtrWidth-1:0]   wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg;
    logic [PtrWidth-1:0]   rd_ptr_next;
    logic [CntWidth-1:0]   count_reg;
    logic [CntWidth-1:0]   count_next;
    logic                  pop;

    assign full          = (count_reg == CntWidth'(DEPTH));
    assign verdict_valid = (count_reg != '0);
    assign verdict_item  = entry_reg[rd_ptr_reg];
    assign pop           = verdict_valid && !verdict_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CntWidth'(push) - CntWidth'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CntWidth'(DEPTH))
        else $error("result buffer count out of range");
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into a full result buffer");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("result buffer count did not grow on push");

endmodule

`default_nettype wire
